// File: hdl/gbt_pkg.sv
package gbt_pkg;

  localparam int NODE_W     = 4;
  localparam int REQ_W      = 2;
  localparam int NODE_SPACE = 2 ** NODE_W;

  localparam int DEF_NODES = 16;
  localparam int DEF_EDGES = 64;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BFS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DFS = 2'd2;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    node_t src;
    node_t dst;
  } edge_t;

  // Control from the sequencer to the frontier queue/stack.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic depth_first;
  } fr_ctrl_t;

  // Address width of a store with n entries; a single entry still gets one bit.
  function automatic int addr_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// File: hdl/gbt_edge_table.sv
module gbt_edge_table #(
  parameter int EDGES = gbt_pkg::DEF_EDGES
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [gbt_pkg::addr_w(EDGES)-1:0]  waddr_i,
  input  gbt_pkg::edge_t                     wdata_i,
  input  logic                               re_i,
  input  logic [gbt_pkg::addr_w(EDGES)-1:0]  raddr_i,
  output gbt_pkg::edge_t                     rdata_o
);
  import gbt_pkg::*;

  edge_t mem_q [EDGES];
  edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/gbt_frontier.sv
module gbt_frontier #(
  parameter int DEPTH = gbt_pkg::DEF_NODES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbt_pkg::fr_ctrl_t ctrl_i,
  input  gbt_pkg::node_t    push_node_i,
  output gbt_pkg::node_t    top_node_o,
  output logic              empty_o
);
  import gbt_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  node_t          store_q [DEPTH];
  logic [PW-1:0]  head_q, head_d;
  logic [PW-1:0]  tail_q, tail_d;
  logic [PW-1:0]  tail_m1;
  logic [IW-1:0]  wr_idx;
  logic [IW-1:0]  rd_idx;

  // Breadth-first pops from the head; depth-first pops from the top of the stack.
  always_comb begin
    tail_m1    = tail_q - PW'(1);
    rd_idx     = ctrl_i.depth_first ? tail_m1[IW-1:0] : head_q[IW-1:0];
    top_node_o = store_q[rd_idx];
    empty_o    = (head_q == tail_q);
    wr_idx     = ctrl_i.clear ? '0 : tail_q[IW-1:0];
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = ctrl_i.push ? PW'(1) : '0;
    end else begin
      if (ctrl_i.push) begin
        tail_d = tail_q + PW'(1);
      end
      if (ctrl_i.pop) begin
        if (ctrl_i.depth_first) begin
          tail_d = tail_m1;
        end else begin
          head_d = head_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      store_q[wr_idx] <= push_node_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && !ctrl_i.clear) |-> (tail_q != PW'(DEPTH)))
    else $error("frontier push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !empty_o)
    else $error("frontier pop while empty");

  a_pop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> (!ctrl_i.push && !ctrl_i.clear))
    else $error("frontier pop mixed with push or clear");
`endif

endmodule

// File: hdl/graph_bfs_dfs_traversal.sv
// Edge transfers can follow back to back while the block is idle.
// In a run, each popped node is followed by a scan of every edge held, read one by one
// through the edge table's single read port.
// Results leave through a one-entry output register; a stalled output stalls the run.
// Reset (rst_ni, asynchronous, active low) clears start_node, the edge count, the visited
// mask and the frontier pointers; the edge table itself is not cleared.
module graph_bfs_dfs_traversal #(
  parameter int NODES = gbt_pkg::DEF_NODES,
  parameter int EDGES = gbt_pkg::DEF_EDGES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  gbt_pkg::node_t                cfg_start_node_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gbt_pkg::REQ_W-1:0]     req_type_i,
  input  gbt_pkg::node_t                edge_from_i,
  input  gbt_pkg::node_t                edge_to_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gbt_pkg::node_t                visited_node_o,
  output logic                          is_last_o
);
  import gbt_pkg::*;

  localparam int CW = $clog2(EDGES + 1);
  localparam int AW = addr_w(EDGES);
  localparam int FD = (NODES < NODE_SPACE) ? NODES : NODE_SPACE;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  node_t                 start_q;
  logic [CW-1:0]         held_q, held_d;
  logic                  mode_q, mode_d;
  logic [NODE_SPACE-1:0] visited_q, visited_d;
  node_t                 pend_q, pend_d;
  logic                  pend_vld_q, pend_vld_d;
  logic [CW-1:0]         e_q, e_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  out_vld_q, out_vld_d;
  node_t                 out_node_q, out_node_d;
  logic                  out_last_q, out_last_d;

  fr_ctrl_t fr_ctrl;
  node_t    fr_push_node;
  node_t    fr_top;
  logic     fr_empty;
  logic     edge_we;
  logic     edge_re;
  edge_t    wr_edge;
  edge_t    rd_edge;
  logic     in_acc;
  logic     out_free;
  logic     out_load;
  logic     issue;
  logic     hit;

  assign in_ready_o     = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_vld_q;
  assign visited_node_o = out_node_q;
  assign is_last_o      = out_last_q;

  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_vld_q || out_ready_i;
  assign wr_edge.src = edge_from_i;
  assign wr_edge.dst = edge_to_i;

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    mode_d       = mode_q;
    visited_d    = visited_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    e_d          = e_q;
    rd_vld_d     = 1'b0;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_node_d   = out_node_q;
    out_last_d   = out_last_q;
    out_load     = 1'b0;
    fr_ctrl      = '0;
    fr_ctrl.depth_first = mode_q;
    fr_push_node = rd_edge.dst;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    issue        = (e_q != held_q);
    // The one compare unit: does the edge leave the current node toward a new node?
    hit          = rd_vld_q && (rd_edge.src == pend_q) && !visited_q[rd_edge.dst];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (req_type_i)
            REQ_ADD: begin
              if ((held_q != CW'(EDGES)) && (int'(edge_from_i) < NODES) &&
                  (int'(edge_to_i) < NODES)) begin
                edge_we = 1'b1;
                held_d  = held_q + CW'(1);
              end
            end
            REQ_BFS, REQ_DFS: begin
              mode_d        = (req_type_i == REQ_DFS);
              visited_d     = '0;
              fr_ctrl.clear = 1'b1;
              if (int'(start_q) < NODES) begin
                fr_ctrl.push       = 1'b1;
                fr_push_node       = start_q;
                visited_d[start_q] = 1'b1;
                state_d            = S_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (fr_empty) begin
          state_d = S_DONE;
        end else if (!pend_vld_q || out_free) begin
          // The previous node is known not to be last once another one is popped.
          fr_ctrl.pop = 1'b1;
          if (pend_vld_q) begin
            out_load   = 1'b1;
            out_vld_d  = 1'b1;
            out_node_d = pend_q;
            out_last_d = 1'b0;
          end
          pend_d     = fr_top;
          pend_vld_d = 1'b1;
          e_d        = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          edge_re = 1'b1;
          e_d     = e_q + CW'(1);
        end
        rd_vld_d = issue;
        if (hit) begin
          fr_ctrl.push           = 1'b1;
          visited_d[rd_edge.dst] = 1'b1;
        end
        if (!issue && !rd_vld_q) begin
          state_d = S_POP;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_vld_d  = 1'b1;
          out_node_d = pend_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      start_q    <= '0;
      held_q     <= '0;
      mode_q     <= 1'b0;
      visited_q  <= '0;
      pend_vld_q <= 1'b0;
      e_q        <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      held_q     <= held_d;
      mode_q     <= mode_d;
      visited_q  <= visited_d;
      pend_vld_q <= pend_vld_d;
      e_q        <= e_d;
      rd_vld_q   <= rd_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i) begin
        start_q <= cfg_start_node_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_node_q <= out_node_d;
    out_last_q <= out_last_d;
  end

  gbt_edge_table #(
    .EDGES(EDGES)
  ) u_edge_table (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (held_q[AW-1:0]),
    .wdata_i (wr_edge),
    .re_i    (edge_re),
    .raddr_i (e_q[AW-1:0]),
    .rdata_o (rd_edge)
  );

  gbt_frontier #(
    .DEPTH(FD)
  ) u_frontier (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fr_ctrl),
    .push_node_i (fr_push_node),
    .top_node_o  (fr_top),
    .empty_o     (fr_empty)
  );

`ifndef SYNTHESIS
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while held");

  a_done_has_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> pend_vld_q)
    else $error("run finished without a node to flag as last");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == S_SCAN))
    else $error("edge read data returned outside the scan");
`endif

endmodule

// File: bench/graph_bfs_dfs_traversal_tb.sv
module graph_bfs_dfs_traversal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbt_pkg::*;

  localparam int NUM_NODES  = DEF_NODES;
  localparam int NUM_EDGES  = DEF_EDGES;
  localparam int HALF_CLK   = 6;
  localparam int RESET_CYC  = 10;
  // An add or an unused request may still be in flight when the last result leaves.
  localparam int SETTLE_CYC = 8;
  localparam int DRAIN_CYC  = 2 * NUM_EDGES + 20;
  // The limit covers a full table scan per popped node plus the longest output stall.
  localparam int IDLE_LIMIT = 4000;
  localparam int SHOW_MAX   = 10;
  localparam int RAND_ITEMS = 100;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    node_t node;
    logic  last_flag;
  } visit_t;

  typedef struct packed {
    logic             is_cfg;
    logic [REQ_W-1:0] req;
    node_t            a;
    node_t            b;
    logic             typed;
    node_t            exp_node;
  } stim_row_t;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             cfg_valid_i      = 1'b0;
  logic             cfg_ready_o;
  node_t            cfg_start_node_i = '0;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic [REQ_W-1:0] req_type_i       = '0;
  node_t            edge_from_i      = '0;
  node_t            edge_to_i        = '0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  node_t            visited_node_o;
  logic             is_last_o;

  graph_bfs_dfs_traversal u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_start_node_i(cfg_start_node_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .edge_from_i     (edge_from_i),
    .edge_to_i       (edge_to_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .visited_node_o  (visited_node_o),
    .is_last_o       (is_last_o)
  );

  // Directed part: a transfer per row; cfg rows write field a as the start node.
  // A typed row is a run whose single visit can be read off directly.
  stim_row_t directed_rows [] = '{
    '{1'b0, REQ_BFS,    4'd0,  4'd0,  1'b1, 4'd0},
    '{1'b0, REQ_DFS,    4'd0,  4'd0,  1'b1, 4'd0},
    '{1'b0, REQ_UNUSED, 4'd15, 4'd15, 1'b0, 4'd0},
    '{1'b1, REQ_ADD,    4'd15, 4'd0,  1'b0, 4'd0},
    '{1'b0, REQ_BFS,    4'd0,  4'd0,  1'b1, 4'd15},
    '{1'b0, REQ_DFS,    4'd15, 4'd15, 1'b1, 4'd15},
    '{1'b0, REQ_ADD,    4'd15, 4'd0,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd0,  4'd1,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd0,  4'd2,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd1,  4'd3,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd2,  4'd3,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd3,  4'd15, 1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd1,  4'd1,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd0,  4'd1,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd15, 4'd15, 1'b0, 4'd0},
    '{1'b0, REQ_BFS,    4'd9,  4'd6,  1'b0, 4'd0},
    '{1'b0, REQ_DFS,    4'd6,  4'd9,  1'b0, 4'd0},
    '{1'b1, REQ_ADD,    4'd0,  4'd0,  1'b0, 4'd0},
    '{1'b0, REQ_BFS,    4'd0,  4'd0,  1'b0, 4'd0},
    '{1'b0, REQ_DFS,    4'd0,  4'd0,  1'b0, 4'd0},
    '{1'b0, REQ_UNUSED, 4'd0,  4'd0,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd2,  4'd9,  1'b0, 4'd0},
    '{1'b0, REQ_ADD,    4'd9,  4'd4,  1'b0, 4'd0},
    '{1'b0, REQ_DFS,    4'd0,  4'd0,  1'b0, 4'd0}
  };

  // Own copy of the block's persistent state.
  node_t  edge_src_tab [NUM_EDGES];
  node_t  edge_dst_tab [NUM_EDGES];
  int     edge_count = 0;
  node_t  start_sel  = '0;
  visit_t expected_visits [$];

  int     fail_count = 0;
  int     shown      = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  bit     no_idle    = 1'b0;
  logic [7:0] stall_pat  = 8'hFF;
  logic [4:0] stall_step = '0;
  visit_t want;

  always #(HALF_CLK) clk_i = ~clk_i;

  task automatic traverse_graph(input bit depth_first);
    node_t             order [$];
    node_t             frontier [NUM_NODES];
    logic [NUM_NODES-1:0] seen;
    int                head;
    int                tail;
    node_t             u;
    seen = '0;
    head = 0;
    tail = 0;
    if (int'(start_sel) < NUM_NODES) begin
      frontier[tail] = start_sel;
      tail++;
      seen[start_sel] = 1'b1;
    end
    while (head < tail) begin
      if (depth_first) begin
        tail--;
        u = frontier[tail];
      end else begin
        u = frontier[head];
        head++;
      end
      order.insert(order.size(), u);
      for (int e = 0; e < edge_count; e++) begin
        if (edge_src_tab[e] == u && int'(edge_dst_tab[e]) < NUM_NODES &&
            !seen[edge_dst_tab[e]] && tail < NUM_NODES) begin
          seen[edge_dst_tab[e]] = 1'b1;
          frontier[tail] = edge_dst_tab[e];
          tail++;
        end
      end
    end
    foreach (order[k]) begin
      expected_visits.insert(expected_visits.size(),
                             visit_t'{order[k], k == order.size() - 1});
    end
  endtask

  task automatic predict_request(input logic [REQ_W-1:0] req, input node_t from,
                                 input node_t to);
    case (req)
      REQ_ADD: begin
        if (edge_count < NUM_EDGES && int'(from) < NUM_NODES && int'(to) < NUM_NODES) begin
          edge_src_tab[edge_count] = from;
          edge_dst_tab[edge_count] = to;
          edge_count++;
        end
      end
      REQ_BFS: traverse_graph(1'b0);
      REQ_DFS: traverse_graph(1'b1);
      default: ;
    endcase
  endtask

  task automatic send_request(input logic [REQ_W-1:0] req, input node_t from,
                              input node_t to, input bit typed, input node_t exp_node);
    int gap;
    if (!no_idle && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    edge_from_i <= from;
    edge_to_i   <= to;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) expected_visits.insert(expected_visits.size(), visit_t'{exp_node, 1'b1});
    else predict_request(req, from, to);
  endtask

  task automatic write_start(input node_t value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_start_node_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    start_sel = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic note_mismatch(input string what);
    fail_count++;
    if (shown < SHOW_MAX) begin
      shown++;
      $display("mismatch: %s", what);
    end
  endtask

  // Receiver stalls follow an 8-bit pattern that is redrawn whenever the 5-bit step counter wraps.
  always @(negedge clk_i) begin
    if (stall_step == '0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    out_ready_i <= stall_pat[stall_step[2:0]];
    stall_step  <= stall_step + 5'd1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_visits.size() == 0) begin
        note_mismatch($sformatf("unexpected visit node=%0d last=%0b",
                                visited_node_o, is_last_o));
      end else begin
        want = expected_visits.pop_front();
        if (visited_node_o !== want.node || is_last_o !== want.last_flag) begin
          note_mismatch($sformatf("expected node=%0d last=%0b, got node=%0d last=%0b",
                                  want.node, want.last_flag, visited_node_o, is_last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("graph_bfs_dfs_traversal verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          done_items;
    int          dropped_adds;
    int          phase_len;
    int          pick;
    logic [REQ_W-1:0] req;
    node_t       value;
    done_items   = 0;
    dropped_adds = 0;
    repeat (RESET_CYC) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_start(directed_rows[i].a);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].a, directed_rows[i].b,
                     directed_rows[i].typed, directed_rows[i].exp_node);
      end
    end

    // Random phases keep growing the table until it is full and adds start to drop.
    while (done_items < RAND_ITEMS || dropped_adds < 4) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) value = ($urandom_range(0, 1) == 0) ? node_t'(0) : node_t'(NUM_NODES - 1);
      else value = node_t'($urandom_range(0, NUM_NODES - 1));
      write_start(value);
      no_idle   = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(6, 14);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) req = REQ_ADD;
        else if (pick < 80) req = REQ_BFS;
        else if (pick < 96) req = REQ_DFS;
        else req = REQ_UNUSED;
        if (req == REQ_UNUSED || (req == REQ_ADD && edge_count >= NUM_EDGES)) begin
          if (req == REQ_ADD) dropped_adds++;
        end else begin
          done_items++;
        end
        send_request(req, node_t'($urandom), node_t'($urandom), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("graph_bfs_dfs_traversal verification clean");
    end else begin
      $display("graph_bfs_dfs_traversal verification failed");
    end
    $finish;
  end

endmodule
